// File: rtl/core/linear_interp_resampler_queue_assert.svh
// Assertion macros for the linear interpolation resampler.
// Included by the top level; define ASSERT_OFF to compile them out.
`ifndef LINEAR_INTERP_RESAMPLER_QUEUE_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
`define LIRQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("lirq check failed");
`define LIRQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("lirq check failed");
`else
`define LIRQ_ASSERT(lbl, clk, rstn, prop)
`define LIRQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/core/lirq_pkg.sv
// Shared types and constants of the linear interpolation resampler.
// No dependencies; imported by the interpolator and the top level.
`timescale 1ns / 1ps

package lirq_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 5;

    // Reset step is round(1.0196 * 2^FRAC_BITS).
    localparam longint unsigned STEP_RESET_NUM = 64'd10196;
    localparam longint unsigned STEP_RESET_DEN = 64'd10000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic    valid;
        sample_t a;
        sample_t b;
    } interp_req_t;

endpackage

// File: rtl/core/lirq_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module lirq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: rtl/core/lirq_interp.sv
// Two-stage linear interpolator: multiply, then add and truncate toward zero.
// Depends on lirq_pkg.
`timescale 1ns / 1ps

module lirq_interp
    import lirq_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  interp_req_t          req,
    input  logic [FRAC_BITS-1:0] frac,
    output logic                 out_valid,
    output sample_t              out_sample,
    output logic                 busy
);

    localparam int PW = SAMPLE_W + 2 + FRAC_BITS;
    localparam int TW = PW + 1;

    logic signed [SAMPLE_W:0]    diff;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        prod_reg;
    sample_t                     a_reg;
    logic                        valid1_reg;
    logic signed [TW-1:0]        total;
    logic signed [TW-1:0]        quot;
    logic                        round_up;
    logic [TW-1:0]               res_wide;
    sample_t                     res_reg;
    logic                        valid2_reg;

    always_comb begin
        diff   = (SAMPLE_W+1)'(req.b) - (SAMPLE_W+1)'(req.a);
        frac_s = {1'b0, frac};
        prod   = PW'(diff) * PW'(frac_s);
    end

    // Truncation toward zero: an arithmetic shift floors, so negative
    // totals with a nonzero fraction are moved up by one.
    always_comb begin
        total    = (TW'(a_reg) <<< FRAC_BITS) + TW'(prod_reg);
        quot     = total >>> FRAC_BITS;
        round_up = total[TW-1] && (total[FRAC_BITS-1:0] != '0);
        res_wide = quot + TW'(round_up);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod;
        a_reg    <= req.a;
        res_reg  <= sample_t'(res_wide[SAMPLE_W-1:0]);
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else begin
            valid1_reg <= req.valid;
            valid2_reg <= valid1_reg;
        end
    end

    assign out_valid  = valid2_reg;
    assign out_sample = res_reg;
    assign busy       = valid1_reg | valid2_reg;

endmodule

// File: rtl/core/linear_interp_resampler_queue.sv
// Linear interpolation fractional resampler with a sample queue in RAM.
// Top level; depends on lirq_pkg, lirq_interp, lirq_ram and the assertion header.
// Usage:
//   s_axis carries one item per transfer: tuser selects feed (0) or pop (1),
//   tdata holds the input sample of a feed. m_axis returns one result per item.
//   cfg_valid/cfg_data write the step (unsigned Q2.FRAC_BITS); write it only
//   while the block is idle. cfg_ready is always high.
// Timing:
//   A feed keeps the input stalled while it runs:
//   one interpolation enters the two-stage multiply pipeline per cycle and each
//   result goes to the single-port queue RAM, or is counted as dropped if it is full.
//   A pop reads the queue through the registered RAM read; an underrun pop
//   skips the read. Items are processed one at a time.
//   The result register decouples the output: a new item is accepted while the
//   previous result waits; if m_axis stalls, the next result waits in its final
//   state and no further item is accepted until the register frees.
// Reset:
//   Phase, previous sample, pointers and fill count clear; the step returns
//   to round(1.0196 * 2^FRAC_BITS). Queue RAM contents are not cleared: only
//   written entries are ever read, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "linear_interp_resampler_queue_assert.svh"

module linear_interp_resampler_queue
    import lirq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2048,
    parameter int FRAC_BITS   = 16,
    localparam int LEVEL_W    = $clog2(QUEUE_DEPTH + 1),
    localparam int STEP_W     = FRAC_BITS + 2,
    localparam int OUT_W      = ((SAMPLE_W + 2 * CNT_W + LEVEL_W + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Input items.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [15:0] sample_in
    input  logic              s_axis_tuser,   // [0] mode
    // Result items.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // sample_out, produced, dropped,
                                              // queue_level, zero fill
    output logic              m_axis_tuser,   // [0] underrun
    // Step register write.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [STEP_W-1:0] cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam longint unsigned STEP_RESET_WIDE =
        ((STEP_RESET_NUM << FRAC_BITS) + STEP_RESET_DEN / 2) / STEP_RESET_DEN;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(STEP_RESET_WIDE);
    localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(64'd1 << (FRAC_BITS - 4));
    localparam logic [STEP_W:0]   ONE_FX     = (STEP_W + 1)'(64'd1 << FRAC_BITS);
    localparam logic [LEVEL_W-1:0] FULL_LVL  = LEVEL_W'(QUEUE_DEPTH);
    localparam logic [AW-1:0]     LAST_PTR   = AW'(QUEUE_DEPTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FEED  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_POP   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [STEP_W-1:0]  phase_reg, phase_next;
    logic [STEP_W:0]    pw_reg, pw_next;
    sample_t            prev_reg, prev_next;
    logic               have_prev_reg, have_prev_next;
    sample_t            a_reg, a_next;
    sample_t            b_reg, b_next;
    logic [AW-1:0]      rptr_reg, rptr_next;
    logic [AW-1:0]      wptr_reg, wptr_next;
    logic [LEVEL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]   prod_cnt_reg, prod_cnt_next;
    logic [CNT_W-1:0]   drop_cnt_reg, drop_cnt_next;
    sample_t            res_sample_reg, res_sample_next;
    logic               res_under_reg, res_under_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;

    logic               in_accept;
    logic [STEP_W-1:0]  step_eff;
    sample_t            s_sample;
    interp_req_t        ireq;
    logic               i_valid;
    sample_t            i_sample;
    logic               i_busy;
    logic               ram_en, ram_we;
    logic [AW-1:0]      ram_addr;
    logic [SAMPLE_W-1:0] ram_rdata;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign s_sample      = sample_t'(s_axis_tdata);
    assign step_eff      = (step_reg < STEP_MIN) ? STEP_MIN : step_reg;

    assign ireq.valid = (state_reg == ST_FEED) && (pw_reg < ONE_FX);
    assign ireq.a     = a_reg;
    assign ireq.b     = b_reg;

    lirq_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (ireq),
        .frac       (pw_reg[FRAC_BITS-1:0]),
        .out_valid  (i_valid),
        .out_sample (i_sample),
        .busy       (i_busy)
    );

    // Writes happen only during a feed, reads only on a pop, so one port suffices.
    assign ram_we   = i_valid && (fill_reg != FULL_LVL);
    assign ram_en   = ram_we || (in_accept && s_axis_tuser);
    assign ram_addr = ram_we ? wptr_reg : rptr_reg;

    lirq_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (i_sample),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        phase_next      = phase_reg;
        pw_next         = pw_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        rptr_next       = rptr_reg;
        wptr_next       = wptr_reg;
        fill_next       = fill_reg;
        prod_cnt_next   = prod_cnt_reg;
        drop_cnt_next   = drop_cnt_reg;
        res_sample_next = res_sample_reg;
        res_under_next  = res_under_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;

        if (cfg_valid) begin
            step_next = cfg_data;
        end
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        // Results leaving the interpolator are queued or counted as dropped.
        if (i_valid) begin
            if (ram_we) begin
                wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
                fill_next = fill_reg + 1'b1;
            end else begin
                drop_cnt_next = drop_cnt_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    prod_cnt_next   = '0;
                    drop_cnt_next   = '0;
                    res_sample_next = '0;
                    res_under_next  = 1'b0;
                    if (!s_axis_tuser) begin
                        b_next     = s_sample;
                        a_next     = have_prev_reg ? prev_reg : s_sample;
                        pw_next    = {1'b0, phase_reg};
                        state_next = ST_FEED;
                    end else if (fill_reg == '0) begin
                        res_under_next = 1'b1;
                        state_next     = ST_DONE;
                    end else begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_FEED: begin
                if (pw_reg < ONE_FX) begin
                    prod_cnt_next = prod_cnt_reg + 1'b1;
                    pw_next       = pw_reg + {1'b0, step_eff};
                end else begin
                    phase_next     = STEP_W'(pw_reg - ONE_FX);
                    prev_next      = b_reg;
                    have_prev_next = 1'b1;
                    state_next     = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_POP: begin
                res_sample_next = sample_t'(ram_rdata);
                rptr_next       = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
                fill_next       = fill_reg - 1'b1;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_under_reg;
                    m_data_next  = OUT_W'({fill_reg, drop_cnt_reg, prod_cnt_reg,
                                           res_sample_reg});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        pw_reg         <= pw_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        prod_cnt_reg   <= prod_cnt_next;
        drop_cnt_reg   <= drop_cnt_next;
        res_sample_reg <= res_sample_next;
        res_under_reg  <= res_under_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_RESET;
            phase_reg     <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            rptr_reg      <= '0;
            wptr_reg      <= '0;
            fill_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            rptr_reg      <= rptr_next;
            wptr_reg      <= wptr_next;
            fill_reg      <= fill_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // The queue never holds more than its depth.
    `LIRQ_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FULL_LVL)
    // The interpolator pipeline is empty whenever a new item can be accepted.
    `LIRQ_ASSERT(a_idle_empty, aclk, aresetn, s_axis_tready |-> !i_busy)
    // Interpolated samples appear only while a feed is in progress.
    `LIRQ_ASSERT(a_push_in_feed, aclk, aresetn,
        i_valid |-> (state_reg == ST_FEED || state_reg == ST_DRAIN))
    // A queue write always raises the fill count by one.
    `LIRQ_ASSERT(a_fill_step, aclk, aresetn,
        (ram_we && state_reg != ST_POP) |=> fill_reg == $past(fill_reg) + 1'b1)

endmodule
